/* rtl/ttps_pkg.sv */
`default_nettype none
package ttps_pkg;

   localparam int unsigned TABLE_ENTRIES = 4096;
   localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int unsigned KEY_W         = 64;
   localparam int unsigned DEPTH_W       = 8;
   localparam int unsigned SCORE_W       = 16;
   localparam int unsigned KIND_W        = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_EXACT = 2'd0,
      KIND_LOWER = 2'd1,
      KIND_UPPER = 2'd2
   } kind_type;

   typedef enum logic {
      REQ_PROBE = 1'b0,
      REQ_STORE = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [DEPTH_W-1:0]  depth;
      logic [SCORE_W-1:0]  score;
      logic [KIND_W-1:0]   kind;
   } entry_type;

   typedef struct packed {
      logic                req_type;
      logic [KEY_W-1:0]    pos_key;
      logic [DEPTH_W-1:0]  search_depth;
      logic [SCORE_W-1:0]  alpha_in;
      logic [SCORE_W-1:0]  beta_in;
   } probe_type;

   typedef struct packed {
      logic                cutoff;
      logic [SCORE_W-1:0]  result_value;
      logic [SCORE_W-1:0]  alpha_out;
      logic [SCORE_W-1:0]  beta_out;
      logic                key_hit;
   } result_type;

endpackage
`default_nettype wire

/* rtl/ttps_req_if.sv */
`default_nettype none
interface ttps_req_if;
   logic                                valid;
   logic                                ready;
   logic                                req_type;
   logic        [ttps_pkg::KEY_W-1:0]   pos_key;
   logic        [ttps_pkg::DEPTH_W-1:0] search_depth;
   logic signed [ttps_pkg::SCORE_W-1:0] entry_score_in;
   logic        [ttps_pkg::KIND_W-1:0]  bound_kind;
   logic signed [ttps_pkg::SCORE_W-1:0] alpha_in;
   logic signed [ttps_pkg::SCORE_W-1:0] beta_in;

   modport source (output valid, req_type, pos_key, search_depth, entry_score_in,
                   bound_kind, alpha_in, beta_in, input ready);
   modport sink   (input valid, req_type, pos_key, search_depth, entry_score_in,
                   bound_kind, alpha_in, beta_in, output ready);
endinterface

interface ttps_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                cutoff;
   logic signed [ttps_pkg::SCORE_W-1:0] result_value;
   logic signed [ttps_pkg::SCORE_W-1:0] alpha_out;
   logic signed [ttps_pkg::SCORE_W-1:0] beta_out;
   logic                                key_hit;

   modport source (output valid, cutoff, result_value, alpha_out, beta_out, key_hit,
                   input ready);
   modport sink   (input valid, cutoff, result_value, alpha_out, beta_out, key_hit,
                   output ready);
endinterface
`default_nettype wire

/* rtl/transposition_table_probe_store_core.sv */
`default_nettype none
// Accept -> stage 1 (table read register) -> result register -> response valid.
// One request per cycle while no clearing pass runs and responses are taken; the
// single-port table does one read or one write per request, and a store's write lands
// before any later probe reads the slot. Reset (synchronous): a clearing pass writes
// all TABLE_ENTRIES (4096) slots invalid, and no request is accepted until it finishes.
module transposition_table_probe_store_core (
   input  wire logic clock,
   input  wire logic reset,
   ttps_req_if.sink  req_ch,
   ttps_rsp_if.source rsp_ch
);
   import ttps_pkg::*;

   entry_type  table_mem [TABLE_ENTRIES];

   logic              clr_busy_ff, clr_busy_in;
   logic [IDX_W-1:0]  clr_idx_ff, clr_idx_in;
   logic              s1_valid_ff, s1_valid_in;
   probe_type         s1_ff;
   entry_type         rd_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff;

   logic              advance;
   logic              accept;
   logic [IDX_W-1:0]  req_idx;
   entry_type         wr_entry;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_idx;
   result_type        res;

   assign req_idx = IDX_W'(req_ch.pos_key % KEY_W'(TABLE_ENTRIES));
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !clr_busy_ff && (!s1_valid_ff || advance);
   assign accept = req_ch.valid && req_ch.ready;

   // clearing pass owns the write port until it finishes
   always_comb begin
      wr_en    = 1'b0;
      wr_idx   = req_idx;
      wr_entry = '0;
      if (clr_busy_ff) begin
         wr_en  = 1'b1;
         wr_idx = clr_idx_ff;
      end else if (accept && req_ch.req_type == REQ_STORE) begin
         wr_en          = 1'b1;
         wr_entry.valid = 1'b1;
         wr_entry.key   = req_ch.pos_key;
         wr_entry.depth = req_ch.search_depth;
         wr_entry.score = req_ch.entry_score_in;
         wr_entry.kind  = req_ch.bound_kind;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_idx] <= wr_entry;
      end
   end

   // only probes read the table; a store's result ignores rd_ff
   always_ff @(posedge clock) begin
      if (accept) begin
         if (req_ch.req_type == REQ_PROBE) begin
            rd_ff <= table_mem[req_idx];
         end
         s1_ff <= '{req_type:     req_ch.req_type,
                    pos_key:      req_ch.pos_key,
                    search_depth: req_ch.search_depth,
                    alpha_in:     req_ch.alpha_in,
                    beta_in:      req_ch.beta_in};
      end
   end

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = advance ? s1_valid_ff : out_valid_ff;
   end

   // bound rules on the entry read for the request in stage 1
   always_comb begin
      logic signed [SCORE_W-1:0] s;
      logic signed [SCORE_W-1:0] a;
      logic signed [SCORE_W-1:0] b;
      logic                      hit;
      logic                      deep_enough;
      s   = rd_ff.score;
      a   = s1_ff.alpha_in;
      b   = s1_ff.beta_in;
      hit = s1_ff.req_type == REQ_PROBE && rd_ff.valid && rd_ff.key == s1_ff.pos_key;
      deep_enough = !(s1_ff.search_depth != '0 && rd_ff.depth < s1_ff.search_depth);
      res = '{cutoff: 1'b0, result_value: '0, alpha_out: a, beta_out: b, key_hit: hit};
      if (hit && deep_enough) begin
         case (rd_ff.kind)
            KIND_EXACT: begin
               res.cutoff = 1'b1;
               if (s >= b) begin
                  res.result_value = b;
               end else if (s <= a) begin
                  res.result_value = a;
               end else begin
                  res.result_value = s;
               end
            end
            KIND_LOWER: begin
               if (s >= b) begin
                  res.cutoff       = 1'b1;
                  res.result_value = b;
               end else if (s > a) begin
                  res.alpha_out = s;
               end
            end
            KIND_UPPER: begin
               if (s <= a) begin
                  res.cutoff       = 1'b1;
                  res.result_value = a;
               end else if (s < b) begin
                  res.beta_out = s;
               end
            end
            default: begin
               res.cutoff = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         out_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         clr_busy_ff  <= clr_busy_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.cutoff       = out_ff.cutoff;
   assign rsp_ch.result_value = out_ff.result_value;
   assign rsp_ch.alpha_out    = out_ff.alpha_out;
   assign rsp_ch.beta_out     = out_ff.beta_out;
   assign rsp_ch.key_hit      = out_ff.key_hit;

endmodule
`default_nettype wire
